[sv/mvt_pkg.sv]
`default_nettype none
package mvt_pkg;

  localparam int unsigned N_DIM   = 4;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned PROD_W  = 2 * Q_W;
  localparam int unsigned SUM_W   = PROD_W + 2;

  typedef logic signed [Q_W-1:0] q_t;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_COL  = 2'd1,
    CMD_ROW  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [1:0] load_row;
    logic [1:0] load_col;
    q_t         load_value;
    q_t         vec_c0;
    q_t         vec_c1;
    q_t         vec_c2;
    q_t         vec_c3;
  } in_t;

  typedef struct packed {
    q_t   res_c0;
    q_t   res_c1;
    q_t   res_c2;
    q_t   res_c3;
    logic saturated;
  } out_t;

  // load enables for the two lane pipeline registers
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctl_t;

endpackage
`default_nettype wire

[sv/mvt_lane.sv]
`default_nettype none
module mvt_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire mvt_pkg::lane_ctl_t ctl,
  input  wire mvt_pkg::q_t        mat_el [4],
  input  wire mvt_pkg::q_t        vec_el [4],
  output mvt_pkg::q_t             res,
  output logic                    clip
);
  import mvt_pkg::*;

  logic signed [PROD_W-1:0] prod_r [N_DIM];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  shifted;
  logic                     fits;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int k = 0; k < N_DIM; k++) begin
        prod_r[k] <= mat_el[k] * vec_el[k];
      end
    end
    if (ctl.ld_sum) begin
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < N_DIM; k++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[k]);
    end
  end

  // floor toward minus infinity, then clip to the 32-bit range
  assign shifted = sum_r >>> FRAC_BITS;
  assign fits    = (&shifted[SUM_W-1:Q_W-1]) || !(|shifted[SUM_W-1:Q_W-1]);
  assign clip    = !fits;

  always_comb begin
    if (fits) begin
      res = shifted[Q_W-1:0];
    end else if (sum_r[SUM_W-1]) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

[sv/mvt_merge.sv]
`default_nettype none
module mvt_merge (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           lane_valid,
  output logic                lane_ready,
  input  wire mvt_pkg::q_t    lane_res  [4],
  input  wire logic [3:0]     lane_clip,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mvt_pkg::out_t       out_data
);
  import mvt_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_data_r;

  assign lane_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (lane_ready) begin
      out_valid_nxt = lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready && lane_valid) begin
      out_data_r.res_c0    <= lane_res[0];
      out_data_r.res_c1    <= lane_res[1];
      out_data_r.res_c2    <= lane_res[2];
      out_data_r.res_c3    <= lane_res[3];
      out_data_r.saturated <= |lane_clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[sv/matrix_vector_transform_4x4.sv]
`default_nettype none
// channel | ports                            | beat
// --------+----------------------------------+---------------------------------
// input   | in_valid, in_ready, in_data      | load element or transform vector
// result  | out_valid, out_ready, out_data   | four components and clip flag
//
// One beat per cycle is taken unless a stall holds in_ready low; a transform
// result passes the product register, sum register and output register in turn.
// Each of the four lanes holds four 32x32 multipliers.
// Reset (rst_n low, synchronous) clears the matrix to zero and empties the pipe.
// A stalled result holds only the stages behind it that are full; empty
// stages keep taking beats. A load takes effect for the very next beat.
module matrix_vector_transform_4x4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mvt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mvt_pkg::out_t      out_data
);
  import mvt_pkg::*;

  q_t        mat_r [N_DIM*N_DIM];
  logic      v1_r;
  logic      v1_nxt;
  logic      v2_r;
  logic      v2_nxt;
  logic      m_ready;
  logic      ld_sum;
  logic      ld_prod;
  lane_ctl_t ctl;
  logic      accept;
  logic      is_xform;
  q_t        vec    [N_DIM];
  q_t        mat_el [N_DIM][N_DIM];
  q_t        lane_res  [N_DIM];
  logic [3:0] lane_clip;

  assign ld_sum      = !v2_r || m_ready;
  assign ld_prod     = !v1_r || ld_sum;
  assign ctl         = '{ld_prod: ld_prod, ld_sum: ld_sum};
  assign in_ready    = ld_prod;
  assign accept      = in_valid && in_ready;
  assign is_xform    = (in_data.command == CMD_COL) || (in_data.command == CMD_ROW);

  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    if (ld_prod) begin
      v1_nxt = accept && is_xform;
    end
    if (ld_sum) begin
      v2_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int e = 0; e < N_DIM*N_DIM; e++) begin
        mat_r[e] <= '0;
      end
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      if (accept && in_data.command == CMD_LOAD) begin
        mat_r[{in_data.load_row, in_data.load_col}] <= in_data.load_value;
      end
    end
  end

  assign vec[0] = in_data.vec_c0;
  assign vec[1] = in_data.vec_c1;
  assign vec[2] = in_data.vec_c2;
  assign vec[3] = in_data.vec_c3;

  // lane i takes row i for M*v, column i for v*M
  always_comb begin
    for (int i = 0; i < N_DIM; i++) begin
      for (int k = 0; k < N_DIM; k++) begin
        if (in_data.command == CMD_ROW) begin
          mat_el[i][k] = mat_r[k*N_DIM + i];
        end else begin
          mat_el[i][k] = mat_r[i*N_DIM + k];
        end
      end
    end
  end

  for (genvar g = 0; g < N_DIM; g++) begin : g_lane
    mvt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .mat_el (mat_el[g]),
      .vec_el (vec),
      .res    (lane_res[g]),
      .clip   (lane_clip[g])
    );
  end

  mvt_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (v2_r),
    .lane_ready (m_ready),
    .lane_res   (lane_res),
    .lane_clip  (lane_clip),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
